// ----- rtl/pit_pkg.sv -----
// ----------------------------------------------------------------------------
// Point-in-triangle package
// Item types and fixed constants shared by the test datapath.
// ----------------------------------------------------------------------------
package pit_pkg;

    localparam int FIELD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TOL_WIDTH   = 17;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] vert_a_x;
        logic signed [FIELD_WIDTH-1:0] vert_a_y;
        logic signed [FIELD_WIDTH-1:0] vert_a_z;
        logic signed [FIELD_WIDTH-1:0] vert_b_x;
        logic signed [FIELD_WIDTH-1:0] vert_b_y;
        logic signed [FIELD_WIDTH-1:0] vert_b_z;
        logic signed [FIELD_WIDTH-1:0] vert_c_x;
        logic signed [FIELD_WIDTH-1:0] vert_c_y;
        logic signed [FIELD_WIDTH-1:0] vert_c_z;
        logic signed [FIELD_WIDTH-1:0] query_x;
        logic signed [FIELD_WIDTH-1:0] query_y;
        logic signed [FIELD_WIDTH-1:0] query_z;
    } in_item_t;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } out_item_t;

endpackage

// ----- rtl/pit_mul.sv -----
// ----------------------------------------------------------------------------
// Point-in-triangle wide multiplier
// Two-stage signed multiplier built from registered chunk products.
// ----------------------------------------------------------------------------
module pit_mul #(
    parameter int AW = 68,
    parameter int BW = 68
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
);
    localparam int CH  = 34;
    localparam int NA  = (AW + CH - 1) / CH;
    localparam int NB  = (BW + CH - 1) / CH;
    localparam int PPW = 2 * (CH + 1);
    localparam int RW  = AW + BW;

    logic signed [NA*CH-1:0] ax;
    logic signed [NB*CH-1:0] bx;
    logic signed [CH:0]      a_ch [NA];
    logic signed [CH:0]      b_ch [NB];
    logic signed [PPW-1:0]   pp_reg [NA][NB];
    logic signed [RW-1:0]    sum;
    logic signed [RW-1:0]    p_reg;

    assign ax = (NA*CH)'(a);
    assign bx = (NB*CH)'(b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                a_ch[i] = {ax[i*CH+CH-1], ax[i*CH +: CH]};
            end else begin
                a_ch[i] = {1'b0, ax[i*CH +: CH]};
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                b_ch[j] = {bx[j*CH+CH-1], bx[j*CH +: CH]};
            end else begin
                b_ch[j] = {1'b0, bx[j*CH +: CH]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= a_ch[i] * b_ch[j];
                end
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                sum = sum + (RW'(pp_reg[i][j]) <<< (CH * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sum;
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/point_in_triangle_test.sv -----
// ----------------------------------------------------------------------------
// Point-in-triangle test
// Exact barycentric inside test of a point against a 3D triangle, pipelined.
// ----------------------------------------------------------------------------
//  port group   direction  handshake          payload
//  s_*          in         s_valid/s_ready    pit_pkg::in_item_t
//  m_*          out        m_valid/m_ready    pit_pkg::out_item_t
//  cfg_*        in         cfg_we             tolerance, 17 bits
//
//  One item per cycle while no held result stalls the pipeline.
//  Depth is set by the chained wide multiplies, each registered in pit_mul.
//  aresetn clears valid bits and tolerance; payload registers are not reset.
//  A held result stalls every stage at once; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module point_in_triangle_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pit_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pit_pkg::out_item_t            m_data,
    input  logic                          cfg_we,
    input  logic [pit_pkg::TOL_WIDTH-1:0] cfg_wdata
);
    localparam int CW  = COORD_WIDTH;
    localparam int DXW = CW + 1;
    localparam int PRW = 2 * DXW;
    localparam int DW  = PRW + 2;
    localparam int PW  = 2 * DW;
    localparam int NW  = PW + 1;
    localparam int TW  = pit_pkg::TOL_WIDTH + 1;
    localparam int TDW = NW + TW;
    localparam int W   = PW + 20;
    localparam int NST = 9;

    localparam int D_APB = 0;
    localparam int D_APC = 1;
    localparam int D_ABB = 2;
    localparam int D_ABC = 3;
    localparam int D_ACC = 4;

    logic                          en;
    logic [NST-1:0]                vld_reg;
    logic [NST-1:0]                vld_next;
    logic [pit_pkg::TOL_WIDTH-1:0] tol_reg;

    logic signed [CW-1:0]  crd [12];
    logic signed [DXW-1:0] ab_reg [3];
    logic signed [DXW-1:0] ac_reg [3];
    logic signed [DXW-1:0] ap_reg [3];
    logic signed [PRW-1:0] prod_reg [5][3];
    logic signed [DW-1:0]  dot_reg [5];
    logic signed [PW-1:0]  mp [6];
    logic signed [NW-1:0]  den_reg [3];
    logic signed [NW-1:0]  un_reg [3];
    logic signed [NW-1:0]  vn_reg [3];
    logic signed [TDW-1:0] td;
    logic signed [W-1:0]   t1;
    logic signed [W-1:0]   t2;
    logic signed [W-1:0]   t3;
    logic                  den_zero;
    pit_pkg::out_item_t    out_reg;
    pit_pkg::out_item_t    out_next;

    assign en      = !vld_reg[NST-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NST-1];
    assign m_data  = out_reg;

    assign vld_next = {vld_reg[NST-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            tol_reg <= '0;
        end else begin
            if (en) begin
                vld_reg <= vld_next;
            end
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    assign crd[0]  = s_data.vert_a_x[CW-1:0];
    assign crd[1]  = s_data.vert_a_y[CW-1:0];
    assign crd[2]  = s_data.vert_a_z[CW-1:0];
    assign crd[3]  = s_data.vert_b_x[CW-1:0];
    assign crd[4]  = s_data.vert_b_y[CW-1:0];
    assign crd[5]  = s_data.vert_b_z[CW-1:0];
    assign crd[6]  = s_data.vert_c_x[CW-1:0];
    assign crd[7]  = s_data.vert_c_y[CW-1:0];
    assign crd[8]  = s_data.vert_c_z[CW-1:0];
    assign crd[9]  = s_data.query_x[CW-1:0];
    assign crd[10] = s_data.query_y[CW-1:0];
    assign crd[11] = s_data.query_z[CW-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                ab_reg[k] <= DXW'(crd[3+k]) - DXW'(crd[k]);
                ac_reg[k] <= DXW'(crd[6+k]) - DXW'(crd[k]);
                ap_reg[k] <= DXW'(crd[9+k]) - DXW'(crd[k]);
            end
            for (int k = 0; k < 3; k++) begin
                prod_reg[D_APB][k] <= ap_reg[k] * ab_reg[k];
                prod_reg[D_APC][k] <= ap_reg[k] * ac_reg[k];
                prod_reg[D_ABB][k] <= ab_reg[k] * ab_reg[k];
                prod_reg[D_ABC][k] <= ab_reg[k] * ac_reg[k];
                prod_reg[D_ACC][k] <= ac_reg[k] * ac_reg[k];
            end
            for (int d = 0; d < 5; d++) begin
                dot_reg[d] <= DW'(prod_reg[d][0]) + DW'(prod_reg[d][1])
                              + DW'(prod_reg[d][2]);
            end
        end
    end

    pit_mul #(.AW(DW), .BW(DW)) u_mul0 (.aclk(aclk), .en(en),
        .a(dot_reg[D_ABB]), .b(dot_reg[D_ACC]), .p(mp[0]));
    pit_mul #(.AW(DW), .BW(DW)) u_mul1 (.aclk(aclk), .en(en),
        .a(dot_reg[D_ABC]), .b(dot_reg[D_ABC]), .p(mp[1]));
    pit_mul #(.AW(DW), .BW(DW)) u_mul2 (.aclk(aclk), .en(en),
        .a(dot_reg[D_APB]), .b(dot_reg[D_ACC]), .p(mp[2]));
    pit_mul #(.AW(DW), .BW(DW)) u_mul3 (.aclk(aclk), .en(en),
        .a(dot_reg[D_APC]), .b(dot_reg[D_ABC]), .p(mp[3]));
    pit_mul #(.AW(DW), .BW(DW)) u_mul4 (.aclk(aclk), .en(en),
        .a(dot_reg[D_APC]), .b(dot_reg[D_ABB]), .p(mp[4]));
    pit_mul #(.AW(DW), .BW(DW)) u_mul5 (.aclk(aclk), .en(en),
        .a(dot_reg[D_APB]), .b(dot_reg[D_ABC]), .p(mp[5]));

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0] <= NW'(mp[0]) - NW'(mp[1]);
            un_reg[0]  <= NW'(mp[2]) - NW'(mp[3]);
            vn_reg[0]  <= NW'(mp[4]) - NW'(mp[5]);
            for (int k = 1; k < 3; k++) begin
                den_reg[k] <= den_reg[k-1];
                un_reg[k]  <= un_reg[k-1];
                vn_reg[k]  <= vn_reg[k-1];
            end
        end
    end

    pit_mul #(.AW(NW), .BW(TW)) u_mul_tol (.aclk(aclk), .en(en),
        .a(den_reg[0]), .b(signed'({1'b0, tol_reg})), .p(td));

    always_comb begin
        den_zero = (den_reg[2] == '0);
        t1 = (W'(un_reg[2]) <<< pit_pkg::FRAC_BITS) + W'(td);
        t2 = (W'(vn_reg[2]) <<< pit_pkg::FRAC_BITS) + W'(td);
        t3 = ((W'(un_reg[2]) + W'(vn_reg[2])) <<< pit_pkg::FRAC_BITS)
             - (W'(td) <<< 1) - (W'(den_reg[2]) <<< pit_pkg::FRAC_BITS);
        out_next.degenerate = den_zero;
        out_next.inside_res = !den_zero && !t1[W-1] && !t2[W-1]
                              && (t3[W-1] || (t3 == '0));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTH
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not track output stall");
    a_degenerate_not_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.inside_res && m_data.degenerate))
        else $error("degenerate result marked inside");
    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
    a_accept_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted item lost at entry");
`endif

endmodule

// ----- verif/tb_point_in_triangle_test.sv -----
// ----------------------------------------------------------------------------
// Point-in-triangle testbench
// Drives triangle and point items through the valid/ready channels with
// random idle cycles on both sides. Each accepted item is scored against an
// exact 256-bit barycentric computation under the current tolerance.
// ----------------------------------------------------------------------------
module tb_point_in_triangle_test;

    localparam int IDLE_MAX   = 17;
    localparam int DRAIN_WAIT = 20;
    localparam int STALL_MAX  = 4000;
    localparam int RAND_ITEMS = 250;

    typedef logic signed [255:0] wide_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    pit_pkg::in_item_t             s_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    pit_pkg::out_item_t            m_data;
    logic                          cfg_we = 1'b0;
    logic [pit_pkg::TOL_WIDTH-1:0] cfg_wdata = '0;

    logic [pit_pkg::TOL_WIDTH-1:0] tol_now = '0;
    pit_pkg::out_item_t            verdict_q[$];
    bit                   idle_on = 1'b1;
    int                   rdy_wait = 0;
    int                   mismatches = 0;
    int                   n_sent = 0;
    int                   n_checked = 0;
    int                   n_inside = 0;
    int                   n_degen = 0;
    int                   quiet_cycles = 0;

    always #10 aclk = ~aclk;

    point_in_triangle_test u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    function automatic pit_pkg::out_item_t barycentric_verdict(
        pit_pkg::in_item_t it, logic [pit_pkg::TOL_WIDTH-1:0] tol);
        wide_t ab[3], ac[3], ap[3];
        wide_t apb, apc, abb, abc, acc, den, un, vn, td, t1, t2, t3, w_tol;
        pit_pkg::out_item_t r;
        ab[0] = it.vert_b_x - it.vert_a_x;
        ab[1] = it.vert_b_y - it.vert_a_y;
        ab[2] = it.vert_b_z - it.vert_a_z;
        ac[0] = it.vert_c_x - it.vert_a_x;
        ac[1] = it.vert_c_y - it.vert_a_y;
        ac[2] = it.vert_c_z - it.vert_a_z;
        ap[0] = it.query_x - it.vert_a_x;
        ap[1] = it.query_y - it.vert_a_y;
        ap[2] = it.query_z - it.vert_a_z;
        apb = ap[0] * ab[0] + ap[1] * ab[1] + ap[2] * ab[2];
        apc = ap[0] * ac[0] + ap[1] * ac[1] + ap[2] * ac[2];
        abb = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
        abc = ab[0] * ac[0] + ab[1] * ac[1] + ab[2] * ac[2];
        acc = ac[0] * ac[0] + ac[1] * ac[1] + ac[2] * ac[2];
        den = abb * acc - abc * abc;
        r = '0;
        if (den == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        un = apb * acc - apc * abc;
        vn = apc * abb - apb * abc;
        w_tol = '0;
        w_tol[pit_pkg::TOL_WIDTH-1:0] = tol;
        td = w_tol * den;
        t1 = un * 65536 + td;
        t2 = vn * 65536 + td;
        t3 = (un + vn) * 65536 - 2 * td - den * 65536;
        r.inside_res = (t1 >= 0) && (t2 >= 0) && (t3 <= 0);
        return r;
    endfunction

    // score accepted items and results
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            verdict_q.push_back(barycentric_verdict(s_data, tol_now));
        end
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result inside=%0b degen=%0b",
                             m_data.inside_res, m_data.degenerate);
            end else begin
                pit_pkg::out_item_t exp_r;
                exp_r = verdict_q.pop_front();
                n_checked++;
                n_inside += exp_r.inside_res;
                n_degen  += exp_r.degenerate;
                if (m_data.inside_res !== exp_r.inside_res ||
                    m_data.degenerate !== exp_r.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: inside exp %0b got %b, degen exp %0b got %b",
                                 n_checked, exp_r.inside_res, m_data.inside_res,
                                 exp_r.degenerate, m_data.degenerate);
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rdy_wait > 0) begin
            rdy_wait--;
            m_ready <= 1'b0;
        end else if (m_ready && m_valid) begin
            rdy_wait = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            m_ready <= (rdy_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("tb_point_in_triangle_test failed");
            $finish;
        end
    end

    task automatic send_item(pit_pkg::in_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        n_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_tolerance(logic [pit_pkg::TOL_WIDTH-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        tol_now = v;
    endtask

    function automatic pit_pkg::in_item_t make_item(int ax, int ay, int az,
                                                    int bx, int by, int bz,
                                                    int cx, int cy, int cz,
                                                    int px, int py, int pz);
        pit_pkg::in_item_t it;
        it.vert_a_x = ax; it.vert_a_y = ay; it.vert_a_z = az;
        it.vert_b_x = bx; it.vert_b_y = by; it.vert_b_z = bz;
        it.vert_c_x = cx; it.vert_c_y = cy; it.vert_c_z = cz;
        it.query_x  = px; it.query_y  = py; it.query_z  = pz;
        return it;
    endfunction

    function automatic pit_pkg::in_item_t random_noise();
        pit_pkg::in_item_t it;
        for (int i = 0; i < 12; i++) it[i*32 +: 32] = $urandom;
        return it;
    endfunction

    // small triangle with a point placed near it in barycentric terms
    function automatic pit_pkg::in_item_t random_triangle(bit degen);
        int sh, ax, ay, az, abx, aby, abz, acx, acy, acz, u, v, k;
        sh  = $urandom_range(0, 14);
        ax  = $urandom; ay = $urandom; az = $urandom;
        ax  = ax >>> 2; ay = ay >>> 2; az = az >>> 2;
        abx = ($urandom_range(0, 2000) - 1000) <<< sh;
        aby = ($urandom_range(0, 2000) - 1000) <<< sh;
        abz = ($urandom_range(0, 2000) - 1000) <<< sh;
        k   = $urandom_range(0, 6) - 3;
        if (degen) begin
            acx = abx * k; acy = aby * k; acz = abz * k;
        end else begin
            acx = ($urandom_range(0, 2000) - 1000) <<< sh;
            acy = ($urandom_range(0, 2000) - 1000) <<< sh;
            acz = ($urandom_range(0, 2000) - 1000) <<< sh;
        end
        u = $urandom_range(0, 40) - 8;
        v = $urandom_range(0, 40) - 8;
        return make_item(ax, ay, az, ax + abx, ay + aby, az + abz, ax + acx, ay + acy,
                         az + acz,
                         ax + (u * abx + v * acx) / 24 + ($urandom_range(0, 4) - 2),
                         ay + (u * aby + v * acy) / 24 + ($urandom_range(0, 4) - 2),
                         az + (u * abz + v * acz) / 24 + ($urandom_range(0, 64) - 32));
    endfunction

    task automatic test_directed();
        int one, mn, mx;
        one = 65536; mn = 32'h8000_0000; mx = 32'h7fff_ffff;
        // unit triangle: inside, vertices, edges, outside
        send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, one/4, one/4, 0));
        send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, one, 0, 0));
        send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, one/2, one/2, 0));
        send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, -1, one/2, 0));
        send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, one/2, one/2 + 1, 0));
        send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, one/4, one/4, mx));
        // degenerate: coincident, collinear
        send_item(make_item(5, 5, 5, 5, 5, 5, 5, 5, 5, 0, 0, 0));
        send_item(make_item(0, 0, 0, one, one, one, 2*one, 2*one, 2*one, one, one, one));
        send_item(make_item(mn, mn, mn, mx, mx, mx, mn, mn, mn, 0, 0, 0));
        // extreme coordinates
        send_item(make_item(mn, mn, mn, mx, mn, mn, mn, mx, mn, 0, 0, mn));
        send_item(make_item(mx, mx, mx, mn, mx, mx, mx, mn, mx, mn, mn, mn));
        send_item(make_item(mn, mx, mn, mx, mn, mx, mn, mn, mx, mx, mx, mx));
        send_item(make_item(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, -1));
        send_item(make_item(0, 0, 0, mx, 0, 0, 0, mx, 0, mn, mn, mn));
    endtask

    task automatic test_tolerance_edges();
        int one;
        one = 65536;
        for (int t = 0; t < 4; t++) begin
            set_tolerance(t == 0 ? 17'd1 : t == 1 ? 17'd32768 : t == 2 ? 17'd65536
                                         : 17'd131071);
            send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, -one/4, one/4, 0));
            send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, one, one, 0));
            send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, -1, -1, 0));
            send_item(make_item(0, 0, 0, one, 0, 0, 0, one, 0, -2*one, 3*one, 7));
        end
    endtask

    task automatic test_random(logic [pit_pkg::TOL_WIDTH-1:0] tol);
        int pick;
        set_tolerance(tol);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 64 == 0) idle_on = $urandom_range(0, 2) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 75)      send_item(random_triangle(1'b0));
            else if (pick < 85) send_item(random_triangle(1'b1));
            else                send_item(random_noise());
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_tolerance_edges();
        test_random(17'd0);
        test_random(17'd65536);
        test_random(17'd131071);
        test_random(17'd1);
        test_random($urandom_range(0, 131071));
        drain();
        $display("ran %0d items under 9 tolerance settings, %0d results checked",
                 n_sent, n_checked);
        $display("%0d inside, %0d degenerate, %0d mismatches", n_inside, n_degen, mismatches);
        if (mismatches == 0 && verdict_q.size() == 0 && n_checked == n_sent) begin
            $display("tb_point_in_triangle_test passed");
        end else begin
            $display("tb_point_in_triangle_test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pit_pkg.sv
rtl/pit_mul.sv
rtl/point_in_triangle_test.sv
verif/tb_point_in_triangle_test.sv
